### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ihrc_pkg.sv
// ----------------------------------------------------------------------------
// ihrc_pkg
// types, codes and constants of the ipv4 header receive check
// ----------------------------------------------------------------------------
package ihrc_pkg;

  // verdict codes
  localparam logic [3:0] ST_ACCEPT     = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_VERSION    = 4'd2;
  localparam logic [3:0] ST_HDR        = 4'd3;
  localparam logic [3:0] ST_TOTAL      = 4'd4;
  localparam logic [3:0] ST_CKSUM      = 4'd5;
  localparam logic [3:0] ST_FRAG       = 4'd6;
  localparam logic [3:0] ST_NOIFACE    = 4'd7;
  localparam logic [3:0] ST_OTHER_DEST = 4'd8;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR    = 2'd3;
  localparam int CFG_DATA_W = 32;

  // header constants
  localparam logic [15:0] HDR_MIN_BYTES = 16'd20;
  localparam logic [3:0]  IPV4_VERSION  = 4'd4;
  localparam logic [15:0] CKSUM_GOOD    = 16'hffff;
  localparam logic [15:0] MF_FLAG       = 16'h2000;
  localparam logic [15:0] FRAG_OFS_MASK = 16'h1fff;
  localparam logic [15:0] BYTE_CNT_MAX  = 16'hffff;

  // byte offsets of captured fields
  localparam logic [15:0] OFS_VER_IHL = 16'd0;
  localparam logic [15:0] OFS_TOT_HI  = 16'd2;
  localparam logic [15:0] OFS_TOT_LO  = 16'd3;
  localparam logic [15:0] OFS_FRAG_HI = 16'd6;
  localparam logic [15:0] OFS_FRAG_LO = 16'd7;
  localparam logic [15:0] OFS_PROTO   = 16'd9;
  localparam logic [15:0] OFS_SRC_LO  = 16'd12;
  localparam logic [15:0] OFS_SRC_HI  = 16'd15;
  localparam logic [15:0] OFS_DST_LO  = 16'd16;
  localparam logic [15:0] OFS_DST_HI  = 16'd19;

  // verdict queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // one finished frame, classified by the front end
  typedef struct packed {
    logic [3:0]  pre_status;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  header_length;
  } ihrc_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ihrc_fifo_stat_t;

endpackage

### hw/rtl/ihrc_in_if.sv
// ----------------------------------------------------------------------------
// ihrc_in_if
// byte stream channel into the header check
// ----------------------------------------------------------------------------
interface ihrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

### hw/rtl/ihrc_out_if.sv
// ----------------------------------------------------------------------------
// ihrc_out_if
// verdict channel out of the header check
// ----------------------------------------------------------------------------
interface ihrc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  protocol;
  logic [15:0] total_length;
  logic [31:0] src_addr;
  logic [5:0]  header_length;

  modport source (output valid, output status, output protocol, output total_length,
                  output src_addr, output header_length, input ready);
  modport sink   (input valid, input status, input protocol, input total_length,
                  input src_addr, input header_length, output ready);
endinterface

### hw/rtl/ihrc_fifo.sv
// ----------------------------------------------------------------------------
// ihrc_fifo
// short queue of classified frames between the parser and the verdict stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ihrc_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  ihrc_pkg::ihrc_rec_t        push_rec,
  input  logic                       pop,
  output ihrc_pkg::ihrc_rec_t        pop_rec,
  output ihrc_pkg::ihrc_fifo_stat_t  stat
);
  import ihrc_pkg::*;

  ihrc_rec_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  assign pop_rec    = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  `ASSERT_IMPL(a_no_overflow, push, !stat.full || pop, "push into full verdict queue")
  `ASSERT_IMPL(a_no_underflow, pop, !stat.empty, "pop from empty verdict queue")
  `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count out of range")
endmodule

### hw/rtl/ihrc_front.sv
// ----------------------------------------------------------------------------
// ihrc_front
// byte parser: captures header fields, keeps the checksum, classifies frames
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ihrc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  ihrc_in_if.sink                    in_s,
  input  ihrc_pkg::ihrc_fifo_stat_t  q_stat,
  output logic                       q_push,
  output ihrc_pkg::ihrc_rec_t        q_rec
);
  import ihrc_pkg::*;

  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic        beat;
  logic [5:0]  hlen;
  logic        in_hdr;
  logic [16:0] word_sum;
  logic [15:0] folded;
  logic [7:0]  b;

  assign in_s.ready = !q_stat.full;
  assign beat       = in_s.valid && in_s.ready;
  assign b          = in_s.data_byte;

  // field capture at fixed offsets
  always_comb begin
    ver_nxt   = (cnt_r == OFS_VER_IHL) ? b : ver_r;
    total_nxt = (cnt_r == OFS_TOT_HI || cnt_r == OFS_TOT_LO) ? {total_r[7:0], b} : total_r;
    frag_nxt  = (cnt_r == OFS_FRAG_HI || cnt_r == OFS_FRAG_LO) ? {frag_r[7:0], b} : frag_r;
    proto_nxt = (cnt_r == OFS_PROTO) ? b : proto_r;
    src_nxt   = (cnt_r >= OFS_SRC_LO && cnt_r <= OFS_SRC_HI) ? {src_r[23:0], b} : src_r;
    dst_nxt   = (cnt_r >= OFS_DST_LO && cnt_r <= OFS_DST_HI) ? {dst_r[23:0], b} : dst_r;
    cnt_nxt   = (cnt_r == BYTE_CNT_MAX) ? cnt_r : cnt_r + 16'd1;
  end

  // ones' complement sum over the header bytes
  always_comb begin
    hlen     = {ver_nxt[3:0], 2'b00};
    in_hdr   = (cnt_r < {10'd0, hlen});
    word_sum = {1'b0, sum_r} + {1'b0, hold_r, b};
    folded   = word_sum[15:0] + {15'd0, word_sum[16]};
    hold_nxt = hold_r;
    sum_nxt  = sum_r;
    if (in_hdr && !cnt_r[0]) begin
      hold_nxt = b;
    end
    if (in_hdr && cnt_r[0]) begin
      sum_nxt = folded;
    end
  end

  // classify on the last beat, checks in priority order
  always_comb begin
    q_rec.protocol      = proto_nxt;
    q_rec.total_length  = total_nxt;
    q_rec.src_addr      = src_nxt;
    q_rec.dst_addr      = dst_nxt;
    q_rec.header_length = hlen;
    if (cnt_nxt < HDR_MIN_BYTES) begin
      q_rec.pre_status = ST_SHORT;
    end else if (ver_nxt[7:4] != IPV4_VERSION) begin
      q_rec.pre_status = ST_VERSION;
    end else if (cnt_nxt < {10'd0, hlen}) begin
      q_rec.pre_status = ST_HDR;
    end else if (cnt_nxt < total_nxt) begin
      q_rec.pre_status = ST_TOTAL;
    end else if (sum_nxt != CKSUM_GOOD) begin
      q_rec.pre_status = ST_CKSUM;
    end else if ((frag_nxt & MF_FLAG) != '0 || (frag_nxt & FRAG_OFS_MASK) != '0) begin
      q_rec.pre_status = ST_FRAG;
    end else begin
      q_rec.pre_status = ST_ACCEPT;
    end
  end

  assign q_push = beat && in_s.last;

  // frame state, cleared after every last beat
  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      cnt_r   <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      ver_r   <= '0;
      total_r <= '0;
      frag_r  <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else if (beat) begin
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      ver_r   <= ver_nxt;
      total_r <= total_nxt;
      frag_r  <= frag_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

  `ASSERT_NEXT(a_clear_after_last, q_push, cnt_r == '0 && sum_r == '0, "frame state not cleared")
  `ASSERT_NEXT(a_cnt_saturate, beat && !in_s.last && cnt_r == BYTE_CNT_MAX,
               cnt_r == BYTE_CNT_MAX, "byte count wrapped")
endmodule

### hw/rtl/ihrc_back.sv
// ----------------------------------------------------------------------------
// ihrc_back
// verdict stage: interface and destination checks, output register
// ----------------------------------------------------------------------------
module ihrc_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ihrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ihrc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  ihrc_pkg::ihrc_fifo_stat_t            q_stat,
  input  ihrc_pkg::ihrc_rec_t                  q_rec,
  output logic                                 q_pop,
  ihrc_out_if.source                           out_m
);
  import ihrc_pkg::*;

  logic        iface_r;
  logic [31:0] local_r;
  logic [31:0] mask_r;
  logic [31:0] bcast_r;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  status_r, status_nxt;
  logic [7:0]  proto_r;
  logic [15:0] total_r;
  logic [31:0] src_r;
  logic [5:0]  hlen_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_r <= 1'b0;
      local_r <= '0;
      mask_r  <= '0;
      bcast_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IFACE_PRESENT: iface_r <= cfg_data[0];
        CFG_LOCAL_ADDR:    local_r <= cfg_data;
        CFG_SUBNET_MASK:   mask_r  <= cfg_data;
        CFG_BCAST_ADDR:    bcast_r <= cfg_data;
        default:           iface_r <= iface_r;
      endcase
    end
  end

  // take a frame when the output register is free or being drained
  assign q_pop = !q_stat.empty && (!out_valid_r || out_m.ready);

  always_comb begin
    if (q_rec.pre_status != ST_ACCEPT) begin
      status_nxt = q_rec.pre_status;
    end else if (!iface_r) begin
      status_nxt = ST_NOIFACE;
    end else if (q_rec.dst_addr != local_r && q_rec.dst_addr != mask_r &&
                 q_rec.dst_addr != bcast_r) begin
      status_nxt = ST_OTHER_DEST;
    end else begin
      status_nxt = ST_ACCEPT;
    end
    out_valid_nxt = q_pop || (out_valid_r && !out_m.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      proto_r  <= q_rec.protocol;
      total_r  <= q_rec.total_length;
      src_r    <= q_rec.src_addr;
      hlen_r   <= q_rec.header_length;
    end
  end

  assign out_m.valid         = out_valid_r;
  assign out_m.status        = status_r;
  assign out_m.protocol      = proto_r;
  assign out_m.total_length  = total_r;
  assign out_m.src_addr      = src_r;
  assign out_m.header_length = hlen_r;
endmodule

### hw/rtl/ipv4_header_receive_check.sv
// ----------------------------------------------------------------------------
// ipv4_header_receive_check
// receive-side ipv4 header validation over a byte stream
// ----------------------------------------------------------------------------
// Takes one datagram byte per beat, one beat per clock unless the queue is full,
// with last marking the final byte of a frame. The parser captures the header
// fields and keeps the ones' complement sum as bytes arrive, and classifies
// the frame on its last beat; a four-entry verdict queue then feeds the stage
// that applies the interface and destination checks and holds the result in
// an output register. Input stalls only once the queue holds four verdicts
// behind a stalled output register. Configuration is to be written through
// cfg_we, cfg_index and cfg_data only while no frame is in progress; the block
// itself does not enforce this.
module ipv4_header_receive_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ihrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ihrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  ihrc_in_if.sink                           in_s,
  ihrc_out_if.source                        out_m
);
  import ihrc_pkg::*;

  logic            q_push;
  logic            q_pop;
  ihrc_rec_t       push_rec;
  ihrc_rec_t       pop_rec;
  ihrc_fifo_stat_t q_stat;

  // parser and classifier
  ihrc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_s   (in_s),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_rec  (push_rec)
  );

  // verdict queue
  ihrc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .stat     (q_stat)
  );

  // verdict stage
  ihrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_m     (out_m)
  );
endmodule

### tb/tb_ipv4_header_receive_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_header_receive_check
// self-checking bench for the receive-side ipv4 header check
// ----------------------------------------------------------------------------
// A short table of frames and register writes covers each verdict code, the
// extremes of the header fields, headers with options, frames cut short
// and a zero header length.
// Random frames follow under several interface settings. Most of them are
// well formed with random content; the rest are broken on purpose, short,
// or plain noise. A bit-level verdict predictor runs on every accepted beat
// and its verdicts are compared with the block's, field by field, in order.
// The sender idles in bursts, the receiver stalls on its own pattern, and
// once the receiver holds off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module tb_ipv4_header_receive_check;
  import ihrc_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_PAD       = 8;
  localparam int PHASE_BYTES     = 200;
  localparam int NUM_PHASES      = 5;

  localparam logic [31:0] HOST_ADDR  = 32'hc0a8_0105;
  localparam logic [31:0] HOST_MASK  = 32'hffff_ff00;
  localparam logic [31:0] HOST_BCAST = 32'hc0a8_01ff;
  localparam logic [31:0] PEER_ADDR  = 32'h0a00_0001;
  localparam logic [15:0] DF_FLAG    = 16'h4000;

  typedef enum logic [1:0] {SUM_GOOD, SUM_BAD, SUM_RAW} sum_mode_t;
  typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_t;

  typedef struct {
    logic [3:0]  status;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic [31:0] src_addr;
    logic [5:0]  header_length;
  } verdict_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [31:0]           reg_val;
    logic [7:0]            ver_ihl;
    logic [15:0]           tot;
    logic [15:0]           frag;
    logic [7:0]            proto;
    logic [31:0]           src;
    logic [31:0]           dst;
    sum_mode_t             sum_mode;
    int unsigned           len;
    bit                    known;
    logic [3:0]            status;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ihrc_in_if  in_ch ();
  ihrc_out_if out_ch ();

  ipv4_header_receive_check DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_s      (in_ch),
    .out_m     (out_ch)
  );

  // shadow of the interface registers
  logic        sh_iface;
  logic [31:0] sh_local;
  logic [31:0] sh_mask;
  logic [31:0] sh_bcast;

  // per-frame parser state of the predictor
  logic [15:0] rx_count;
  logic [16:0] rx_sum;
  logic [7:0]  rx_hold;
  logic [7:0]  rx_ver_ihl;
  logic [15:0] rx_total;
  logic [15:0] rx_frag;
  logic [7:0]  rx_proto;
  logic [31:0] rx_src;
  logic [31:0] rx_dst;

  verdict_t    verdict_q[$];
  logic [7:0]  frame_bytes[$];
  dir_row_t    steps[$];
  int          bad_verdicts = 0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  bit          typed_known = 0;
  logic [3:0]  typed_status = ST_ACCEPT;
  bit          hold_off_go = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_frame_state();
    rx_count   = '0;
    rx_sum     = '0;
    rx_hold    = '0;
    rx_ver_ihl = '0;
    rx_total   = '0;
    rx_frag    = '0;
    rx_proto   = '0;
    rx_src     = '0;
    rx_dst     = '0;
  endfunction

  // advance the parser by one byte; returns 1 with the verdict on a last byte
  function automatic bit predict_verdict(input logic [7:0] b, input logic is_last,
                                         output verdict_t v);
    logic [5:0]  hlen;
    logic [16:0] s;
    v = '{default: '0};
    // field capture by byte offset
    if (rx_count == OFS_VER_IHL) rx_ver_ihl = b;
    else if (rx_count == OFS_TOT_HI || rx_count == OFS_TOT_LO) rx_total = {rx_total[7:0], b};
    else if (rx_count == OFS_FRAG_HI || rx_count == OFS_FRAG_LO) rx_frag = {rx_frag[7:0], b};
    else if (rx_count == OFS_PROTO) rx_proto = b;
    else if (rx_count >= OFS_SRC_LO && rx_count <= OFS_SRC_HI) rx_src = {rx_src[23:0], b};
    else if (rx_count >= OFS_DST_LO && rx_count <= OFS_DST_HI) rx_dst = {rx_dst[23:0], b};

    // ones' complement sum over the header bytes only
    hlen = {rx_ver_ihl[3:0], 2'b00};
    if (rx_count < {10'd0, hlen}) begin
      if (!rx_count[0]) begin
        rx_hold = b;
      end else begin
        s = rx_sum + {1'b0, rx_hold, b};
        rx_sum = {1'b0, s[15:0]} + {16'd0, s[16]};
      end
    end
    if (rx_count != BYTE_CNT_MAX) rx_count = rx_count + 16'd1;
    if (!is_last) return 1'b0;

    // verdict, first failing check wins
    if (rx_count < HDR_MIN_BYTES) v.status = ST_SHORT;
    else if (rx_ver_ihl[7:4] != IPV4_VERSION) v.status = ST_VERSION;
    else if (rx_count < {10'd0, hlen}) v.status = ST_HDR;
    else if (rx_count < rx_total) v.status = ST_TOTAL;
    else if (rx_sum != {1'b0, CKSUM_GOOD}) v.status = ST_CKSUM;
    else if ((rx_frag & MF_FLAG) != 0 || (rx_frag & FRAG_OFS_MASK) != 0) v.status = ST_FRAG;
    else if (!sh_iface) v.status = ST_NOIFACE;
    else if (rx_dst != sh_local && rx_dst != sh_mask && rx_dst != sh_bcast)
      v.status = ST_OTHER_DEST;
    else v.status = ST_ACCEPT;
    v.protocol      = rx_proto;
    v.total_length  = rx_total;
    v.src_addr      = rx_src;
    v.header_length = hlen;
    clear_frame_state();
    return 1'b1;
  endfunction

  // lay out a datagram in frame_bytes: header fields, checksum, then payload
  function automatic void build_frame(input logic [7:0] ver_ihl, input logic [15:0] tot,
                                      input logic [15:0] frag, input logic [7:0] proto,
                                      input logic [31:0] src, input logic [31:0] dst,
                                      input sum_mode_t sum_mode, input int unsigned len);
    logic [7:0]  hdr [60];
    logic [16:0] acc;
    int unsigned hlen;
    int          i;
    for (i = 0; i < 60; i++) hdr[i] = 8'($urandom);
    hdr[0]  = ver_ihl;
    {hdr[2], hdr[3]} = tot;
    {hdr[6], hdr[7]} = frag;
    hdr[9]  = proto;
    {hdr[12], hdr[13], hdr[14], hdr[15]} = src;
    {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
    hlen = ver_ihl[3:0] * 4;
    // the checksum field only counts when the header covers it
    if (sum_mode != SUM_RAW && hlen >= 12) begin
      hdr[10] = 8'h00;
      hdr[11] = 8'h00;
      acc = '0;
      for (i = 0; i < int'(hlen); i += 2) begin
        acc = acc + {1'b0, hdr[i], hdr[i+1]};
        acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
      end
      {hdr[10], hdr[11]} = ~acc[15:0];
      if (sum_mode == SUM_BAD) hdr[11] = hdr[11] ^ 8'h01;
    end
    frame_bytes.delete();
    for (i = 0; i < int'(len); i++)
      frame_bytes.push_back(i < 60 ? hdr[i] : 8'($urandom));
  endfunction

  function automatic dir_row_t fr(input logic [7:0] ver_ihl, input logic [15:0] tot,
                                  input logic [15:0] frag, input logic [7:0] proto,
                                  input logic [31:0] src, input logic [31:0] dst,
                                  input sum_mode_t sum_mode, input int unsigned len,
                                  input bit known, input logic [3:0] status);
    dir_row_t r;
    r = '{kind: ROW_FRAME, reg_idx: CFG_IFACE_PRESENT, reg_val: '0, ver_ihl: ver_ihl,
          tot: tot, frag: frag, proto: proto, src: src, dst: dst, sum_mode: sum_mode,
          len: len, known: known, status: status};
    return r;
  endfunction

  function automatic dir_row_t cr(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    dir_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, ver_ihl: '0, tot: '0, frag: '0,
          proto: '0, src: '0, dst: '0, sum_mode: SUM_RAW, len: 0, known: 1'b0,
          status: ST_ACCEPT};
    return r;
  endfunction

  // one beat on the byte channel; sender idles between bursts
  task automatic push_byte(input logic [7:0] b, input logic is_last);
    verdict_t v;
    int       gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(9, 24);
      else gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= is_last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (predict_verdict(b, is_last, v)) begin
      if (typed_known) v.status = typed_status;
      verdict_q.push_back(v);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++)
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // stop sending and let every pending verdict come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_IFACE_PRESENT: sh_iface = val[0];
      CFG_LOCAL_ADDR:    sh_local = val;
      CFG_SUBNET_MASK:   sh_mask  = val;
      CFG_BCAST_ADDR:    sh_bcast = val;
      default: ;
    endcase
  endtask

  // mostly well-formed datagrams, some broken, some noise
  task automatic random_frame();
    logic [7:0]  vi;
    logic [15:0] tot;
    logic [15:0] frag;
    logic [31:0] dst;
    sum_mode_t   sm;
    int unsigned hlen;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    vi   = {IPV4_VERSION, ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(5, 15))};
    hlen = vi[3:0] * 4;
    len  = hlen + $urandom_range(0, 20);
    tot  = ($urandom_range(0, 3) != 0) ? 16'(len) : 16'($urandom_range(0, len));
    case ($urandom_range(0, 9))
      0:       frag = DF_FLAG;
      1:       frag = MF_FLAG;
      2:       frag = 16'($urandom);
      default: frag = '0;
    endcase
    case ($urandom_range(0, 4))
      1:       dst = sh_mask;
      2:       dst = sh_bcast;
      3:       dst = $urandom;
      default: dst = sh_local;
    endcase
    sm = SUM_GOOD;
    if (pick >= 70 && pick < 85) begin
      // one defect in an otherwise good frame
      case ($urandom_range(0, 4))
        0: vi[7:4] = 4'($urandom);
        1: vi[3:0] = 4'($urandom_range(0, 4));
        2: len = (hlen > 20) ? $urandom_range(20, hlen - 1) : $urandom_range(1, 19);
        3: tot = 16'(len + $urandom_range(1, 1500));
        default: sm = SUM_BAD;
      endcase
    end else if (pick >= 85 && pick < 95) begin
      vi   = 8'($urandom);
      tot  = 16'($urandom);
      frag = 16'($urandom);
      dst  = $urandom;
      sm   = SUM_RAW;
      len  = $urandom_range(1, 64);
    end else if (pick >= 95) begin
      len = $urandom_range(1, 19);
    end
    build_frame(vi, tot, frag, 8'($urandom), $urandom, dst, sm, len);
    send_frame();
  endtask

  // receiver: changing stall patterns plus one long hold-off
  initial begin : result_sink
    int   mode;
    int   span;
    int   hold_left;
    bit   hold_done;
    logic rdy;
    mode = 0;
    span = 0;
    hold_left = 0;
    hold_done = 0;
    rdy = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_off_go && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_OFF_CYCLES - 1;
        rdy = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ~rdy;
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      bad_verdicts++;
    end
  endfunction

  // compare each verdict beat with the oldest prediction
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict, status expected none got 0x%0h",
                 $time, out_ch.status);
        bad_verdicts++;
      end else begin
        want = verdict_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("protocol", 32'(want.protocol), 32'(out_ch.protocol));
        check_field("total_length", 32'(want.total_length), 32'(out_ch.total_length));
        check_field("src_addr", want.src_addr, out_ch.src_addr);
        check_field("header_length", 32'(want.header_length), 32'(out_ch.header_length));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    int          phase;
    int          phase_start;
    logic        iface;
    logic [31:0] a_local;
    logic [31:0] a_mask;
    logic [31:0] a_bcast;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last      <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    rst_n           <= 1'b0;
    sh_iface = 1'b0;
    sh_local = '0;
    sh_mask  = '0;
    sh_bcast = '0;
    clear_frame_state();

    // directed frames and register writes
    steps.push_back(fr(8'hff, 16'd0, 16'd0, 8'd0, 32'd0, 32'd0, SUM_RAW, 1, 1, ST_SHORT));
    steps.push_back(fr(8'h45, 16'd20, 16'd0, 8'd6, PEER_ADDR, 32'd0, SUM_GOOD, 20, 1,
                       ST_NOIFACE));
    // cut before the destination is complete
    steps.push_back(fr(8'h45, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 19, 1,
                       ST_SHORT));
    steps.push_back(cr(CFG_IFACE_PRESENT, 32'd1));
    steps.push_back(fr(8'h45, 16'd20, 16'd0, 8'd17, PEER_ADDR, 32'd0, SUM_GOOD, 20, 1,
                       ST_ACCEPT));
    steps.push_back(cr(CFG_LOCAL_ADDR, HOST_ADDR));
    steps.push_back(cr(CFG_SUBNET_MASK, HOST_MASK));
    steps.push_back(cr(CFG_BCAST_ADDR, HOST_BCAST));
    steps.push_back(fr(8'h45, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 20, 1,
                       ST_ACCEPT));
    steps.push_back(fr(8'h45, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_MASK, SUM_GOOD, 20, 1,
                       ST_ACCEPT));
    steps.push_back(fr(8'h45, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_BCAST, SUM_GOOD, 20, 1,
                       ST_ACCEPT));
    steps.push_back(fr(8'h45, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR + 1, SUM_GOOD, 20, 1,
                       ST_OTHER_DEST));
    steps.push_back(fr(8'h05, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 20, 1,
                       ST_VERSION));
    steps.push_back(fr(8'hf5, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 20, 1,
                       ST_VERSION));
    // full-size header, frame too short for it, then complete
    steps.push_back(fr(8'h4f, 16'd40, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 40, 1,
                       ST_HDR));
    steps.push_back(fr(8'h4f, 16'd60, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 60, 1,
                       ST_ACCEPT));
    steps.push_back(fr(8'h45, 16'hffff, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 20, 1,
                       ST_TOTAL));
    steps.push_back(fr(8'h45, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_BAD, 20, 1,
                       ST_CKSUM));
    // zero header length never passes the checksum
    steps.push_back(fr(8'h40, 16'd20, 16'd0, 8'd6, PEER_ADDR, HOST_ADDR, SUM_RAW, 20, 1,
                       ST_CKSUM));
    steps.push_back(fr(8'h45, 16'd20, MF_FLAG, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 20, 1,
                       ST_FRAG));
    steps.push_back(fr(8'h45, 16'd20, FRAG_OFS_MASK, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD,
                       20, 1, ST_FRAG));
    steps.push_back(fr(8'h45, 16'd20, DF_FLAG, 8'd6, PEER_ADDR, HOST_ADDR, SUM_GOOD, 20, 1,
                       ST_ACCEPT));
    // padded frame with one option word and all-ones fields
    steps.push_back(fr(8'h46, 16'd21, 16'd0, 8'hff, 32'hffff_ffff, HOST_ADDR, SUM_GOOD, 64,
                       0, ST_ACCEPT));

    // synchronous reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (steps[i]) begin
      row = steps[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        typed_known  = row.known;
        typed_status = row.status;
        build_frame(row.ver_ihl, row.tot, row.frag, row.proto, row.src, row.dst,
                    row.sum_mode, row.len);
        send_frame();
        typed_known = 0;
      end
    end

    // random frames under several interface settings
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin iface = 1'b1; a_local = '1; a_mask = '1; a_bcast = '1; end
        2: begin iface = 1'b0; a_local = $urandom; a_mask = $urandom; a_bcast = $urandom; end
        3: begin iface = 1'b1; a_local = '0; a_mask = '0; a_bcast = '0; end
        4: begin iface = 1'b1; a_local = $urandom; a_mask = '1; a_bcast = '0; end
        default: begin
          iface = 1'b1; a_local = $urandom; a_mask = $urandom; a_bcast = $urandom;
        end
      endcase
      settle();
      write_reg(CFG_IFACE_PRESENT, {31'd0, iface});
      write_reg(CFG_LOCAL_ADDR, a_local);
      write_reg(CFG_SUBNET_MASK, a_mask);
      write_reg(CFG_BCAST_ADDR, a_bcast);
      // long receiver hold-off while frames keep coming
      if (phase == 0) hold_off_go = 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) random_frame();
    end

    settle();
    if (bad_verdicts == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ihrc_pkg.sv
hw/rtl/ihrc_in_if.sv
hw/rtl/ihrc_out_if.sv
hw/rtl/ihrc_fifo.sv
hw/rtl/ihrc_front.sv
hw/rtl/ihrc_back.sv
hw/rtl/ipv4_header_receive_check.sv
tb/tb_ipv4_header_receive_check.sv
